// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppt_pkg.sv =====
package ppt_pkg;

	// Command codes
	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_SET_TIME = 3'd1,
		CMD_CHAPTER  = 3'd2,
		CMD_ARM_LOOP = 3'd3,
		CMD_CANCEL   = 3'd4,
		CMD_TAKE     = 3'd5,
		CMD_REWIND   = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	// Configuration register indexes
	localparam logic [1:0] REG_LOOP_ENABLE  = 2'd0;
	localparam logic [1:0] REG_REVERSE      = 2'd1;
	localparam logic [1:0] REG_PAUSED       = 2'd2;
	localparam logic [1:0] REG_TOTAL        = 2'd3;

	// Tick arithmetic: 32-bit time plus sign and carry
	localparam int NEXT_W    = 34;
	localparam int DIV_STEPS = NEXT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TAKE,
		S_CROSS,
		S_ABS,
		S_DIV,
		S_WRAP,
		S_DONE
	} state_t;

endpackage

// ===== rtl/playback_position_timeline.sv =====
// Requests pass S_IDLE, S_EXEC and S_DONE for non-tick commands and ticks with no effect;
// ticks that move or clamp also pass S_TAKE and S_CROSS, and a looping wrap adds S_ABS,
// S_DIV (34-step remainder unit) and S_WRAP. One request at a time; in_stall is high until
// the result is loaded. Request latch, scratch and result data are not reset.
// The result register lets the next request in while a result waits.
// Reset (arst_n low): sequencer, config, timeline state, marks and out_valid clear to zero.
`include "assert_macros.svh"

module playback_position_timeline (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] amount,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	input  logic        follow_on,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] position,
	output logic        finished,
	output logic        completion_taken,
	output logic        cancelled_flag,
	output logic        loop_armed
);
	import ppt_pkg::*;

	// configuration
	logic        loop_en_q;
	logic        reverse_q;
	logic        paused_q;
	logic [31:0] total_q;

	// timeline state
	logic [31:0] ct_q;
	logic [31:0] ws_q;
	logic [31:0] we_q;
	logic [31:0] ls_q;
	logic [31:0] le_q;
	logic        lp_q;
	logic        done_q;
	logic        compl_q;
	logic        cancel_q;

	// request latch and scratch
	cmd_t               cmd_q;
	logic [31:0]        amt_q;
	logic [31:0]        rs_q;
	logic [31:0]        re_q;
	logic               follow_q;
	logic               taken_q;
	logic signed [NEXT_W-1:0] next_q;
	logic [NEXT_W-1:0]  num_q;
	logic               neg_q;
	logic [31:0]        len_q;
	logic [31:0]        rem_q;
	logic [CNT_W-1:0]   cnt_q;

	// result register
	logic        out_valid_q;
	logic [31:0] pos_q;
	logic        fin_q;
	logic        took_q;
	logic        canc_q;
	logic        armed_q;

	state_t state_q, state_d;

	logic accept;
	logic out_free;
	logic tick_idle;
	logic take_loop;
	logic crossed;
	logic [31:0] win_len;
	logic wrap_ok;
	logic signed [NEXT_W-1:0] fwd_off;
	logic [NEXT_W-1:0] rev_dist;
	logic [32:0] trial;
	logic [31:0] rem_d;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// tick decode terms
	assign tick_idle = paused_q || done_q || cancel_q || (amt_q == '0);
	assign take_loop = lp_q && (reverse_q ?
		(next_q <= $signed({2'b00, le_q})) :
		(next_q >= $signed({2'b00, ls_q})));
	assign crossed = reverse_q ? (next_q < $signed({2'b00, ws_q})) :
		(next_q > $signed({2'b00, we_q}));
	assign win_len  = we_q - ws_q;
	assign wrap_ok  = loop_en_q && (win_len != '0);
	assign fwd_off  = next_q - $signed({2'b00, ws_q});
	assign rev_dist = {2'b00, amt_q} + {2'b00, ws_q} - {2'b00, ct_q};

	// restoring remainder step: shift in one dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[NEXT_W-1]};
		if (trial >= {1'b0, len_q}) begin
			rem_d = 32'(trial - {1'b0, len_q});
		end else begin
			rem_d = trial[31:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd_q == CMD_TICK && !tick_idle) state_d = S_TAKE;
				else state_d = S_DONE;
			end
			S_TAKE: state_d = S_CROSS;
			S_CROSS: begin
				if (crossed && wrap_ok) state_d = S_ABS;
				else state_d = S_DONE;
			end
			S_ABS: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_WRAP;
			end
			S_WRAP: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q <= 1'b0;
			reverse_q <= 1'b0;
			paused_q  <= 1'b0;
			total_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOOP_ENABLE: loop_en_q <= cfg_data[0];
				REG_REVERSE:     reverse_q <= cfg_data[0];
				REG_PAUSED:      paused_q  <= cfg_data[0];
				REG_TOTAL:       total_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// timeline state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_q     <= '0;
			ws_q     <= '0;
			we_q     <= '0;
			ls_q     <= '0;
			le_q     <= '0;
			lp_q     <= 1'b0;
			done_q   <= 1'b0;
			compl_q  <= 1'b0;
			cancel_q <= 1'b0;
		end else begin
			case (state_q)
				S_EXEC: begin
					case (cmd_q)
						CMD_SET_TIME: begin
							ct_q     <= amt_q;
							done_q   <= 1'b0;
							compl_q  <= 1'b0;
							cancel_q <= 1'b0;
						end
						CMD_CHAPTER: begin
							ct_q     <= reverse_q ? re_q : rs_q;
							ws_q     <= follow_q ? '0 : rs_q;
							we_q     <= follow_q ? total_q : re_q;
							done_q   <= 1'b0;
							compl_q  <= 1'b0;
							cancel_q <= 1'b0;
						end
						CMD_ARM_LOOP: begin
							ls_q <= rs_q;
							le_q <= re_q;
							lp_q <= 1'b1;
						end
						CMD_CANCEL: begin
							cancel_q <= 1'b1;
							compl_q  <= 1'b0;
							done_q   <= 1'b0;
						end
						CMD_TAKE: compl_q <= 1'b0;
						CMD_REWIND: begin
							ct_q     <= '0;
							ws_q     <= '0;
							we_q     <= total_q;
							ls_q     <= '0;
							le_q     <= '0;
							lp_q     <= 1'b0;
							done_q   <= 1'b0;
							compl_q  <= 1'b0;
							cancel_q <= 1'b0;
						end
						default: ;
					endcase
				end
				// pending loop window takes over once reached
				S_TAKE: begin
					if (take_loop) begin
						ws_q <= ls_q;
						we_q <= le_q;
						lp_q <= 1'b0;
					end
				end
				// edge check: move, clamp, or hand off to the wrap path
				S_CROSS: begin
					if (!crossed) begin
						ct_q <= next_q[31:0];
					end else if (!wrap_ok) begin
						ct_q <= reverse_q ? ws_q : we_q;
						if (!loop_en_q) begin
							done_q  <= 1'b1;
							compl_q <= 1'b1;
						end
					end
				end
				S_WRAP: begin
					if (reverse_q) ct_q <= we_q - rem_q;
					else if (neg_q) ct_q <= ws_q - rem_q;
					else ct_q <= ws_q + rem_q;
				end
				default: ;
			endcase
		end
	end

	// request latch and arithmetic scratch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(command);
			amt_q    <= amount;
			rs_q     <= range_start;
			re_q     <= range_end;
			follow_q <= follow_on;
		end
		case (state_q)
			S_EXEC: begin
				taken_q <= (cmd_q == CMD_TAKE) && compl_q;
				if (reverse_q) next_q <= $signed({2'b00, ct_q} - {2'b00, amt_q});
				else next_q <= $signed({2'b00, ct_q} + {2'b00, amt_q});
			end
			S_CROSS: begin
				len_q <= win_len;
				rem_q <= '0;
				cnt_q <= '0;
				if (reverse_q) begin
					num_q <= rev_dist;
					neg_q <= 1'b0;
				end else begin
					num_q <= fwd_off;
					neg_q <= fwd_off[NEXT_W-1];
				end
			end
			S_ABS: begin
				if (neg_q) num_q <= -num_q;
			end
			S_DIV: begin
				rem_q <= rem_d;
				num_q <= {num_q[NEXT_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			pos_q   <= ct_q;
			fin_q   <= done_q;
			took_q  <= taken_q;
			canc_q  <= cancel_q;
			armed_q <= lp_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign position         = pos_q;
	assign finished         = fin_q;
	assign completion_taken = took_q;
	assign cancelled_flag   = canc_q;
	assign loop_armed       = armed_q;

	// checks
	`ASSERT_NOW(a_rem_below_len, (state_q == S_DIV && cnt_q != '0), (rem_q < len_q), "remainder not below window length")
	`ASSERT_NOW(a_marks_exclusive, 1'b1, !(done_q && cancel_q), "done and cancel marks both set")
	`ASSERT_NEXT(a_accept_exec, accept, (state_q == S_EXEC), "accepted request not executed")
	`ASSERT_NOW(a_result_source, $rose(out_valid_q), ($past(state_q) == S_DONE), "result raised outside result load")

endmodule
